/* hdl/spq_pkg.sv */
package spq_pkg;

    // item opcodes
    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } opcode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [31:0] item_value;
        logic [7:0]         item_priority;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] out_value;
        logic [7:0]         out_priority;
        logic [4:0]         occupancy;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS_RD,
        S_INS_CMP,
        S_DEQ_WAIT,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd_head;
        logic    rd_tail;
        logic    shift;
        logic    place;
        logic    pop;
        logic    set_status;
        status_t status;
        logic    publish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_dequeue;
        logic empty;
        logic full;
        logic pos_zero;
        logic prio_greater;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/spq_ctrl.sv */
module spq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  spq_pkg::dp_status_t stat,
    output logic               item_stall,
    output spq_pkg::ctrl_cmd_t cmd
);
    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.is_dequeue)
                begin
                    if (stat.empty)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_EMPTY;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = S_DEQ_WAIT;
                    end
                end
                else if (stat.full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FULL;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                // reached the head: new entry goes first
                if (stat.pos_zero)
                begin
                    cmd.place      = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_ENQUEUED;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_tail = 1'b1;
                    state_next  = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (stat.prio_greater)
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cmd.place      = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_ENQUEUED;
                    state_next     = S_DONE;
                end
            end
            S_DEQ_WAIT:
            begin
                cmd.pop        = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_DEQUEUED;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/spq_dpath.sv */
module spq_dpath #(
    parameter int CAPACITY       = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::item_t      item,
    input  spq_pkg::ctrl_cmd_t  cmd,
    input  logic                result_stall,
    output spq_pkg::dp_status_t stat,
    output logic                result_valid,
    output spq_pkg::result_t    result
);
    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]    value;
        logic [PRIORITY_WIDTH-1:0] prio;
    } entry_t;

    entry_t mem [CAPACITY];

    entry_t          rd_data_reg;
    entry_t          req_reg;
    entry_t          wr_data;
    logic            req_deq_reg;
    logic [AW-1:0]   head_reg;
    logic [AW-1:0]   head_next;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   pos_reg;
    status_t         res_status_reg;
    logic [31:0]     res_value_reg;
    logic [7:0]      res_prio_reg;
    logic            result_valid_reg;
    result_t         result_reg;

    // logical list position to circular buffer address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] lidx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(lidx);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_addr = cmd.rd_head ? head_reg : phys(head_reg, pos_reg - CW'(1));
    assign wr_addr = phys(head_reg, pos_reg);
    assign wr_data = cmd.shift ? rd_data_reg : req_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.shift || cmd.place)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_head || cmd.rd_tail)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg.value <= VALUE_WIDTH'($unsigned(item.item_value));
            req_reg.prio  <= PRIORITY_WIDTH'(item.item_priority);
            req_deq_reg   <= (item.opcode == OP_DEQUEUE);
            pos_reg       <= count_reg;
            res_value_reg <= '0;
            res_prio_reg  <= '0;
        end
        else
        begin
            if (cmd.shift)
            begin
                pos_reg <= pos_reg - CW'(1);
            end
            if (cmd.pop)
            begin
                res_value_reg <= 32'(rd_data_reg.value);
                res_prio_reg  <= 8'(rd_data_reg.prio);
            end
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.publish)
        begin
            result_reg.status       <= res_status_reg;
            result_reg.out_value    <= res_value_reg;
            result_reg.out_priority <= res_prio_reg;
            result_reg.occupancy    <= 5'(count_reg);
        end
    end

    always_comb
    begin
        head_next = head_reg;
        if (cmd.pop)
        begin
            head_next = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + AW'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.place)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.publish)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_dequeue   = req_deq_reg;
    assign stat.empty        = (count_reg == '0);
    assign stat.full         = (count_reg == CW'(CAPACITY));
    assign stat.pos_zero     = (pos_reg == '0);
    assign stat.prio_greater = (rd_data_reg.prio > req_reg.prio);
    assign stat.out_free     = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* hdl/sorted_list_priority_queue.sv */
// stable min-first priority queue held as a sorted circular list
//
// item channel (item_valid / item_stall / item): opcode enqueue or dequeue,
//   a value and a priority; a transfer happens when valid is high and stall low
// result channel (result_valid / result_stall / result): one result per item
//   with status, the removed head entry on dequeue, and the occupancy after it
// an enqueue lands behind every entry of lower or equal priority, so equal
//   priorities leave in arrival order; full drops the item, empty reports it
// sequence: a dequeue goes through start, a head read and a pop before its
//   result is published; empty or full goes from start straight to done; an
//   enqueue walks from the tail, each step a read and then a compare that moves
//   one entry back or places the new one, through the one read port of memory
// one item at a time: item_stall is low only when the controller is idle, so
//   a new item is not taken before the result of the last one is published
// a waiting result sits in the output register while the next item is taken;
//   if result_stall is still high when the next result is ready the
//   controller holds it and the item channel stays stalled
// reset clears the entry count, head pointer and result valid; entry
//   storage is not cleared since only live entries are ever read
module sorted_list_priority_queue #(
    parameter int CAPACITY       = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  spq_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output spq_pkg::result_t result
);
    import spq_pkg::*;

    // command and status between controller and datapath
    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // sequencing: dispatch, tail walk, head pop, result hand-off
    spq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .stat       (stat),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // entry memory, head/count pointers, request and result registers
    spq_dpath #(
        .CAPACITY       (CAPACITY),
        .VALUE_WIDTH    (VALUE_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result_stall (result_stall),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* hdl/spq_checker.sv */
module spq_checker #(
    parameter int CAPACITY = 16
) (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input spq_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input spq_pkg::result_t result
);
    import spq_pkg::*;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item taken while previous item in flight");

    // empty dequeue reports nothing held and zero data
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_EMPTY |->
            result.occupancy == '0 && result.out_value == '0 && result.out_priority == '0)
        else $error("empty result carries data");

    // dropped enqueue only when full
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_FULL |-> result.occupancy == 5'(CAPACITY))
        else $error("full reported below capacity");

endmodule

bind sorted_list_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
